/* rtl/ppp_pkg.sv */
// ----------------------------------------------------------------------------
// ppp_pkg
// Types and constants shared by the probe packet pacer modules.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int unsigned DVD_W  = 48;  // divider dividend / quotient width
  localparam int unsigned DVS_W  = 32;  // divider divisor width
  localparam int unsigned TI_W   = 14;  // target interval, at most 10485 ms
  localparam int unsigned SC_W   = 15;  // step count / step index
  localparam int unsigned IVL_W  = 29;  // step interval, wide enough for ti * sc
  localparam int unsigned PLX_W  = 30;  // packet_length * 8000
  localparam int unsigned MUL_W  = 46;  // target_rate * target_interval

  localparam logic [31:0]    MIN_BITRATE   = 32'd50000;
  localparam logic [32:0]    JUMP_ROUND_UP = 33'd149999;
  localparam logic [31:0]    BITRATE_JUMP  = 32'd150000;
  localparam logic [PLX_W-1:0] PL_SCALE    = PLX_W'(8000);
  localparam logic [31:0]    TS_INCREMENT  = 32'd20;
  localparam logic [15:0]    PL_RESET      = 16'd1200;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_PKT_LEN  = 2'd0,
    REG_INIT_SEQ = 2'd1,
    REG_INIT_TS  = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LAUNCH,
    ST_WAIT,
    ST_MUL
  } state_e;

  // which quotient the divider is working on
  typedef enum logic [2:0] {
    OP_SC,
    OP_TI,
    OP_IV0,
    OP_IVN,
    OP_RATE
  } op_e;

endpackage

/* rtl/ppp_div.sv */
// ----------------------------------------------------------------------------
// ppp_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ppp_pkg::DVD_W-1:0]  dividend_i,
  input  logic [ppp_pkg::DVS_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [ppp_pkg::DVD_W-1:0]  quotient_o
);
  import ppp_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  // dividend shifts out the top while quotient bits fill in from the bottom
  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W - 1);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : DVS_W'(rem_sh);
      dvd_d = {dvd_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

/* rtl/probe_packet_pacer_core.sv */
// ----------------------------------------------------------------------------
// probe_packet_pacer_core
// Bandwidth-probe pacer: millisecond ticks, start and stop commands, step
// sequencing with one shared bit-serial divider.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------
//  cfg     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//  in      | in_valid_i / in_stall_o   | cmd_i, bitrate_i
//  out     | out_valid_o / out_stall_i | send_packet_o .. step_interval_o
//
//  One beat in, one beat out. A tick that loads no step, a stop or an ignored
//  command goes from execution straight to output; a step load runs the
//  interval quotient, one multiply and the bitrate quotient, a start the step
//  count, target interval and warm-up interval quotients in the 48-bit divider.
//  The input stalls while a beat is in work or the output beat is held.
//  Reset stops probing, packet_length 1200, sequence and timestamp 0.
// ----------------------------------------------------------------------------
module probe_packet_pacer_core #(
  parameter int unsigned PACKETS_PER_STEP = 50,
  parameter int unsigned STEP_DURATION_MS = 500
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] bitrate_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        send_packet_o,
  output logic [15:0] sequence_number_o,
  output logic [31:0] rtp_timestamp_o,
  output logic        step_reached_o,
  output logic        probe_ended_o,
  output logic        is_running_o,
  output logic [14:0] current_step_o,
  output logic        step_loaded_o,
  output logic [31:0] step_bitrate_o,
  output logic [31:0] step_interval_o
);
  import ppp_pkg::*;

  localparam int unsigned EL_W = $clog2(STEP_DURATION_MS + 1);
  localparam int unsigned PK_W = $clog2(PACKETS_PER_STEP + 2);
  localparam logic [EL_W-1:0] DUR = EL_W'(STEP_DURATION_MS);
  localparam logic [PK_W-1:0] PPS = PK_W'(PACKETS_PER_STEP);

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [1:0]       cmd_q, cmd_d;
  logic [31:0]      brate_q, brate_d;
  logic [15:0]      pl_q, pl_d;
  logic             run_q, run_d;
  logic [31:0]      tr_q, tr_d;
  logic [SC_W-1:0]  sc_q, sc_d;
  logic [SC_W-1:0]  idx_q, idx_d;
  logic [TI_W-1:0]  ti_q, ti_d;
  logic [EL_W-1:0]  el_q, el_d;
  logic [PK_W-1:0]  pk_q, pk_d;
  logic [IVL_W-1:0] cd_q, cd_d;
  logic [IVL_W-1:0] rep_q, rep_d;
  logic [IVL_W-1:0] ivl_q, ivl_d;
  logic [15:0]      seq_q, seq_d;
  logic [31:0]      ts_q, ts_d;
  logic [MUL_W-1:0] mul_q, mul_d;

  logic             ov_q, ov_d;
  logic             o_send_q, o_send_d;
  logic [15:0]      o_seq_q, o_seq_d;
  logic [31:0]      o_ts_q, o_ts_d;
  logic             o_reach_q, o_reach_d;
  logic             o_end_q, o_end_d;
  logic             o_load_q, o_load_d;
  logic [31:0]      o_rate_q, o_rate_d;
  logic [31:0]      o_ivl_q, o_ivl_d;

  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_q;

  logic             in_acc;
  logic [PLX_W-1:0] plx;
  logic [IVL_W-1:0] prod_ts;
  logic [IVL_W-1:0] q_ivl;

  assign in_stall_o = (state_q != ST_IDLE) || (ov_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign plx        = PLX_W'(pl_q) * PL_SCALE;
  assign prod_ts    = IVL_W'(ti_q) * IVL_W'(sc_q);
  // an interval of zero is raised to one
  assign q_ivl      = (div_q[IVL_W-1:0] == '0) ? IVL_W'(1) : div_q[IVL_W-1:0];

  ppp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_comb begin
    logic [EL_W-1:0]  el_n;
    logic [IVL_W-1:0] cd_n;
    logic             go_on;
    logic             do_load;
    logic [IVL_W-1:0] ld_ivl;
    logic [31:0]      ld_rate;

    state_d = state_q;
    op_d    = op_q;
    cmd_d   = cmd_q;
    brate_d = brate_q;
    pl_d    = pl_q;
    run_d   = run_q;
    tr_d    = tr_q;
    sc_d    = sc_q;
    idx_d   = idx_q;
    ti_d    = ti_q;
    el_d    = el_q;
    pk_d    = pk_q;
    cd_d    = cd_q;
    rep_d   = rep_q;
    ivl_d   = ivl_q;
    seq_d   = seq_q;
    ts_d    = ts_q;
    mul_d   = mul_q;

    ov_d      = ov_q && out_stall_i;
    o_send_d  = o_send_q;
    o_seq_d   = o_seq_q;
    o_ts_d    = o_ts_q;
    o_reach_d = o_reach_q;
    o_end_d   = o_end_q;
    o_load_d  = o_load_q;
    o_rate_d  = o_rate_q;
    o_ivl_d   = o_ivl_q;

    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;

    el_n    = el_q;
    cd_n    = cd_q;
    go_on   = 1'b1;
    do_load = 1'b0;
    ld_ivl  = ivl_q;
    ld_rate = MIN_BITRATE;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d   = cmd_i;
          brate_d = bitrate_i;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        o_send_d  = 1'b0;
        o_seq_d   = '0;
        o_ts_d    = '0;
        o_reach_d = 1'b0;
        o_end_d   = 1'b0;
        o_load_d  = 1'b0;
        o_rate_d  = '0;
        o_ivl_d   = '0;
        state_d   = ST_IDLE;
        ov_d      = 1'b1;
        case (cmd_e'(cmd_q))
          CMD_START: begin
            if (!run_q) begin
              run_d   = 1'b1;
              tr_d    = (brate_q < MIN_BITRATE) ? MIN_BITRATE : brate_q;
              idx_d   = '0;
              op_d    = OP_SC;
              state_d = ST_LAUNCH;
              ov_d    = 1'b0;
            end
          end
          CMD_STOP: begin
            if (run_q) begin
              run_d = 1'b0;
              tr_d  = '0;
              sc_d  = '0;
              idx_d = '0;
              ti_d  = '0;
              el_d  = '0;
              pk_d  = '0;
              cd_d  = '0;
              rep_d = '0;
            end
          end
          CMD_TICK: begin
            if (run_q) begin
              if (el_q < DUR) el_n = el_q + 1'b1;
              el_d = el_n;
              if (cd_q != '0) begin
                cd_n = cd_q - 1'b1;
                cd_d = cd_n;
                if (cd_n == '0) begin
                  cd_d = rep_q;
                  if (pk_q < PPS) begin
                    pk_d     = pk_q + 1'b1;
                    seq_d    = seq_q + 16'd1;
                    ts_d     = ts_q + TS_INCREMENT;
                    o_send_d = 1'b1;
                    o_seq_d  = seq_d;
                    o_ts_d   = ts_d;
                  end else if (pk_q == PPS) begin
                    pk_d = PPS + 1'b1;
                    // cap reached early: one-shot for the rest of the step
                    if (el_n < DUR) begin
                      cd_d  = IVL_W'(DUR) - IVL_W'(el_n);
                      rep_d = '0;
                      go_on = 1'b0;
                    end
                  end
                  if (go_on && (el_n >= DUR || rep_q == '0)) begin
                    if (idx_q == '0) begin
                      idx_d   = SC_W'(1);
                      op_d    = OP_IVN;
                      state_d = ST_LAUNCH;
                      ov_d    = 1'b0;
                    end else if (idx_q >= sc_q) begin
                      run_d   = 1'b0;
                      tr_d    = '0;
                      sc_d    = '0;
                      idx_d   = '0;
                      ti_d    = '0;
                      el_d    = '0;
                      pk_d    = '0;
                      cd_d    = '0;
                      rep_d   = '0;
                      o_end_d = 1'b1;
                    end else begin
                      o_reach_d = 1'b1;
                      idx_d     = idx_q + 1'b1;
                      op_d      = OP_IVN;
                      state_d   = ST_LAUNCH;
                      ov_d      = 1'b0;
                    end
                  end
                end
              end
            end
          end
          default: ;
        endcase
      end

      ST_LAUNCH: begin
        div_start = 1'b1;
        state_d   = ST_WAIT;
        case (op_q)
          OP_SC: begin
            div_dvd = DVD_W'({1'b0, tr_q} + JUMP_ROUND_UP);
            div_dvs = BITRATE_JUMP;
          end
          OP_TI: begin
            div_dvd = DVD_W'(plx);
            div_dvs = tr_q;
          end
          OP_IV0: begin
            div_dvd = DVD_W'(plx);
            div_dvs = MIN_BITRATE;
          end
          OP_IVN: begin
            div_dvd = DVD_W'(prod_ts);
            div_dvs = DVS_W'(idx_q);
          end
          OP_RATE: begin
            // round half up: (2 * num + ivl) / (2 * ivl)
            div_dvd = DVD_W'({mul_q, 1'b0}) + DVD_W'(ivl_q);
            div_dvs = DVS_W'({ivl_q, 1'b0});
          end
          default: ;
        endcase
      end

      ST_MUL: begin
        mul_d   = MUL_W'(tr_q) * MUL_W'(ti_q);
        op_d    = OP_RATE;
        state_d = ST_LAUNCH;
      end

      ST_WAIT: begin
        if (div_done) begin
          case (op_q)
            OP_SC: begin
              sc_d    = div_q[SC_W-1:0];
              op_d    = OP_TI;
              state_d = ST_LAUNCH;
            end
            OP_TI: begin
              ti_d    = (div_q[TI_W-1:0] == '0) ? TI_W'(1) : div_q[TI_W-1:0];
              op_d    = OP_IV0;
              state_d = ST_LAUNCH;
            end
            OP_IV0: begin
              do_load = 1'b1;
              ld_ivl  = q_ivl;
              ld_rate = MIN_BITRATE;
            end
            OP_IVN: begin
              ivl_d   = q_ivl;
              state_d = ST_MUL;
            end
            OP_RATE: begin
              do_load = 1'b1;
              ld_ivl  = ivl_q;
              ld_rate = (div_q[DVD_W-1:32] != '0) ? '1 : div_q[31:0];
            end
            default: ;
          endcase
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (do_load) begin
      el_d     = '0;
      pk_d     = '0;
      cd_d     = ld_ivl;
      rep_d    = ld_ivl;
      o_load_d = 1'b1;
      o_rate_d = ld_rate;
      o_ivl_d  = 32'(ld_ivl);
      ov_d     = 1'b1;
      state_d  = ST_IDLE;
    end

    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_PKT_LEN:  pl_d  = cfg_data_i[15:0];
        REG_INIT_SEQ: seq_d = cfg_data_i[15:0];
        REG_INIT_TS:  ts_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_SC;
      pl_q    <= PL_RESET;
      run_q   <= 1'b0;
      tr_q    <= '0;
      sc_q    <= '0;
      idx_q   <= '0;
      ti_q    <= '0;
      el_q    <= '0;
      pk_q    <= '0;
      cd_q    <= '0;
      rep_q   <= '0;
      seq_q   <= '0;
      ts_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      pl_q    <= pl_d;
      run_q   <= run_d;
      tr_q    <= tr_d;
      sc_q    <= sc_d;
      idx_q   <= idx_d;
      ti_q    <= ti_d;
      el_q    <= el_d;
      pk_q    <= pk_d;
      cd_q    <= cd_d;
      rep_q   <= rep_d;
      seq_q   <= seq_d;
      ts_q    <= ts_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    brate_q   <= brate_d;
    ivl_q     <= ivl_d;
    mul_q     <= mul_d;
    o_send_q  <= o_send_d;
    o_seq_q   <= o_seq_d;
    o_ts_q    <= o_ts_d;
    o_reach_q <= o_reach_d;
    o_end_q   <= o_end_d;
    o_load_q  <= o_load_d;
    o_rate_q  <= o_rate_d;
    o_ivl_q   <= o_ivl_d;
  end

  assign out_valid_o       = ov_q;
  assign send_packet_o     = o_send_q;
  assign sequence_number_o = o_seq_q;
  assign rtp_timestamp_o   = o_ts_q;
  assign step_reached_o    = o_reach_q;
  assign probe_ended_o     = o_end_q;
  assign is_running_o      = run_q;
  assign current_step_o    = idx_q;
  assign step_loaded_o     = o_load_q;
  assign step_bitrate_o    = o_rate_q;
  assign step_interval_o   = o_ivl_q;

endmodule
